// File: sv/tbf_pkg.sv
// Shared types, constants and helpers for the tile background filter.
package tbf_pkg;

	localparam int CNT_W     = 18;
	localparam int CNT_MAX   = (1 << CNT_W) - 1;
	localparam int PIX_W     = 8;
	localparam int RATIO_W   = 9;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = RATIO_W;

	localparam int MAX_PIXELS_DEF = 262143;

	// Gray weights (BGR to gray, Q14) and rounding term.
	localparam logic [13:0] GRAY_W0    = 14'd1868;
	localparam logic [13:0] GRAY_W1    = 14'd9617;
	localparam logic [13:0] GRAY_W2    = 14'd4899;
	localparam logic [21:0] GRAY_ROUND = 22'd8192;

	localparam logic [PIX_W-1:0]   WHITE_THR_RST   = 8'd230;
	localparam logic [RATIO_W-1:0] WHITE_SHARE_RST = 9'd128;
	localparam logic [PIX_W-1:0]   COLOR_THR_RST   = 8'd100;
	localparam logic [PIX_W-1:0]   COLOR_MARGIN_RST = 8'd10;
	localparam logic [RATIO_W-1:0] COLOR_SHARE_RST = 9'd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHITE_THR    = 3'd0,
		REG_WHITE_SHARE  = 3'd1,
		REG_COLOR_THR    = 3'd2,
		REG_COLOR_MARGIN = 3'd3,
		REG_COLOR_SHARE  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0]   white_thr;
		logic [RATIO_W-1:0] white_share;
		logic [PIX_W-1:0]   color_thr;
		logic [PIX_W-1:0]   color_margin;
		logic [RATIO_W-1:0] color_share;
	} cfg_t;

	typedef struct packed {
		logic white;
		logic color;
	} px_flags_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
		input logic [CNT_W-1:0] cap);
		return (v >= cap) ? v : v + 1'b1;
	endfunction

endpackage

// File: sv/tbf_ifs.sv
// Handshake channel interfaces for pixels in and tile verdicts out.
interface tbf_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] chan_zero;
	logic [7:0] chan_one;
	logic [7:0] chan_two;
	logic       last_pixel;

	modport source (output valid, chan_zero, chan_one, chan_two, last_pixel, input ready);
	modport sink   (input valid, chan_zero, chan_one, chan_two, last_pixel, output ready);
endinterface

interface tbf_res_if;
	logic        valid;
	logic        ready;
	logic        is_white;
	logic        is_colored;
	logic        discard;
	logic [17:0] white_total;
	logic [17:0] color_total;

	modport source (output valid, is_white, is_colored, discard, white_total, color_total,
		input ready);
	modport sink   (input valid, is_white, is_colored, discard, white_total, color_total,
		output ready);
endinterface

// File: sv/tbf_classify.sv
// Per-pixel classification: white by gray level, colored by a dominant green or red channel.
module tbf_classify (
	input  tbf_pkg::cfg_t      cfg,
	input  logic [7:0]         chan_zero,
	input  logic [7:0]         chan_one,
	input  logic [7:0]         chan_two,
	output tbf_pkg::px_flags_t flags
);
	import tbf_pkg::*;

	logic [21:0] gray_sum;
	logic [7:0]  gray;
	logic [8:0]  c0_m, c1_m, c2_m;
	logic        dom_one, dom_two;

	// Largest sum is 255*16384 + 8192, fits in 22 bits.
	assign gray_sum = 22'(chan_zero * GRAY_W0) + 22'(chan_one * GRAY_W1)
		+ 22'(chan_two * GRAY_W2) + GRAY_ROUND;
	assign gray = gray_sum[21:14];

	assign c0_m = {1'b0, chan_zero} + {1'b0, cfg.color_margin};
	assign c1_m = {1'b0, chan_one}  + {1'b0, cfg.color_margin};
	assign c2_m = {1'b0, chan_two}  + {1'b0, cfg.color_margin};

	assign dom_one = (chan_one > cfg.color_thr) && ({1'b0, chan_one} > c0_m)
		&& ({1'b0, chan_one} > c2_m);
	assign dom_two = (chan_two > cfg.color_thr) && ({1'b0, chan_two} > c0_m)
		&& ({1'b0, chan_two} > c1_m);

	assign flags.white = gray > cfg.white_thr;
	assign flags.color = dom_one || dom_two;

endmodule

// File: sv/tile_background_filter.sv
// Tile background filter top level.
// Pixels enter on pix, one transfer per cycle unless stalled; each is registered, classified
// (white by rounded BGR gray level, colored by a dominant green or red channel) and counted.
// The pixel flagged last_pixel closes the tile: its counts are latched, compared against the
// ratio registers (count*256 > ratio*total) and one verdict leaves on res, after which the
// counters restart from zero. The pipeline is input register, flag register, tile-total
// register and output register, each with its own valid so a waiting verdict does not stop
// pixels behind it until the next last pixel reaches the counters. Counters saturate at
// min(MAX_PIXELS, 262143). Configuration writes (cfg_we, cfg_idx, cfg_data) take effect on
// the next cycle; unknown indexes are ignored; write only while no tile is in flight.
module tile_background_filter #(
	parameter int MAX_PIXELS = tbf_pkg::MAX_PIXELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tbf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tbf_pkg::CFG_DATA_W-1:0] cfg_data,
	tbf_pix_if.sink                        pix,
	tbf_res_if.source                      res
);
	import tbf_pkg::*;

	localparam logic [CNT_W-1:0] CntCap =
		(MAX_PIXELS > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(MAX_PIXELS);

	cfg_t cfg_q;

	// stage 1: input register
	logic       valid_s1, last_s1;
	logic [7:0] c0_s1, c1_s1, c2_s1;
	// stage 2: pixel flags
	logic       valid_s2, last_s2;
	px_flags_t  flags_s1, flags_s2;
	// stage 3: closed tile totals
	logic             valid_s3;
	logic [CNT_W-1:0] white_s3, color_s3, total_s3;
	// running counters
	logic [CNT_W-1:0] white_cnt_q, color_cnt_q, pix_cnt_q;
	logic [CNT_W-1:0] white_nxt, color_nxt, pix_nxt;
	// output register
	logic             out_valid_q, out_white_q, out_color_q;
	logic [CNT_W-1:0] out_wtot_q, out_ctot_q;

	logic out_free, s3_free, s2_move, s2_free, s1_move, s1_free;
	logic [CNT_W+RATIO_W-1:0] white_lhs, white_rhs, color_lhs, color_rhs;
	logic cmp_white, cmp_color;

	assign out_free = !out_valid_q || res.ready;
	assign s3_free  = !valid_s3 || out_free;
	assign s2_move  = valid_s2 && (!last_s2 || s3_free);
	assign s2_free  = !valid_s2 || s2_move;
	assign s1_move  = valid_s1 && s2_free;
	assign s1_free  = !valid_s1 || s1_move;
	assign pix.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.white_thr    <= WHITE_THR_RST;
			cfg_q.white_share  <= WHITE_SHARE_RST;
			cfg_q.color_thr    <= COLOR_THR_RST;
			cfg_q.color_margin <= COLOR_MARGIN_RST;
			cfg_q.color_share  <= COLOR_SHARE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_WHITE_THR:    cfg_q.white_thr    <= cfg_data[PIX_W-1:0];
				REG_WHITE_SHARE:  cfg_q.white_share  <= cfg_data;
				REG_COLOR_THR:    cfg_q.color_thr    <= cfg_data[PIX_W-1:0];
				REG_COLOR_MARGIN: cfg_q.color_margin <= cfg_data[PIX_W-1:0];
				REG_COLOR_SHARE:  cfg_q.color_share  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && pix.valid) begin
			c0_s1   <= pix.chan_zero;
			c1_s1   <= pix.chan_one;
			c2_s1   <= pix.chan_two;
			last_s1 <= pix.last_pixel;
		end
	end

	tbf_classify u_classify (
		.cfg       (cfg_q),
		.chan_zero (c0_s1),
		.chan_one  (c1_s1),
		.chan_two  (c2_s1),
		.flags     (flags_s1)
	);

	// Stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			flags_s2 <= flags_s1;
			last_s2  <= last_s1;
		end
	end

	// Counters: the last pixel is counted into the tile totals, then they restart.
	assign white_nxt = flags_s2.white ? sat_inc(white_cnt_q, CntCap) : white_cnt_q;
	assign color_nxt = flags_s2.color ? sat_inc(color_cnt_q, CntCap) : color_cnt_q;
	assign pix_nxt   = sat_inc(pix_cnt_q, CntCap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_cnt_q <= '0;
			color_cnt_q <= '0;
			pix_cnt_q   <= '0;
		end else if (s2_move) begin
			if (last_s2) begin
				white_cnt_q <= '0;
				color_cnt_q <= '0;
				pix_cnt_q   <= '0;
			end else begin
				white_cnt_q <= white_nxt;
				color_cnt_q <= color_nxt;
				pix_cnt_q   <= pix_nxt;
			end
		end
	end

	// Stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= s2_move && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move && last_s2) begin
			white_s3 <= white_nxt;
			color_s3 <= color_nxt;
			total_s3 <= pix_nxt;
		end
	end

	assign white_lhs = {1'b0, white_s3, 8'd0};
	assign color_lhs = {1'b0, color_s3, 8'd0};
	assign white_rhs = cfg_q.white_share * total_s3;
	assign color_rhs = cfg_q.color_share * total_s3;
	assign cmp_white = white_lhs > white_rhs;
	assign cmp_color = color_lhs > color_rhs;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s3) begin
			out_white_q <= cmp_white;
			out_color_q <= cmp_color;
			out_wtot_q  <= white_s3;
			out_ctot_q  <= color_s3;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.is_white    = out_white_q;
	assign res.is_colored  = out_color_q;
	assign res.discard     = out_white_q || out_color_q;
	assign res.white_total = out_wtot_q;
	assign res.color_total = out_ctot_q;

endmodule

// File: verif/tile_background_filter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tile_background_filter: pixel tiles in, verdicts checked.
module tile_background_filter_tb;
	import tbf_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int CNT_CAP      = 262143;
	localparam int unsigned WT_CH0 = 1868;
	localparam int unsigned WT_CH1 = 9617;
	localparam int unsigned WT_CH2 = 4899;
	localparam int unsigned WT_RND = 8192;
	localparam int REG_COUNT    = 5;
	localparam int HOLD_CYCLES  = 120;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 100;
	localparam int LONG_TILE_LEN = 250;
	localparam longint LIMIT_NS = 2_000_000;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		logic       last;
	} pixel_t;

	typedef struct packed {
		logic        is_white;
		logic        is_colored;
		logic        discard;
		logic [17:0] white_total;
		logic [17:0] color_total;
	} verdict_t;

	typedef struct packed {
		logic [8:0] white_thr;
		logic [8:0] white_share;
		logic [8:0] color_thr;
		logic [8:0] color_margin;
		logic [8:0] color_share;
	} setting_t;

	// Tracks the tile counters and holds the verdicts still owed by the block.
	class tile_judge;
		logic [7:0]  white_thr;
		logic [8:0]  white_share;
		logic [7:0]  color_thr;
		logic [7:0]  color_margin;
		logic [8:0]  color_share;
		logic [17:0] white_cnt;
		logic [17:0] color_cnt;
		logic [17:0] pix_cnt;
		verdict_t    pending_verdicts[$];
		int          errors;
		int          pixels;
		int          tiles;
		int          white_tiles;
		int          colored_tiles;
		int          discarded;

		function new();
			white_thr = 8'd230;
			white_share = 9'd128;
			color_thr = 8'd100;
			color_margin = 8'd10;
			color_share = 9'd128;
			white_cnt = '0;
			color_cnt = '0;
			pix_cnt = '0;
			errors = 0;
			pixels = 0;
			tiles = 0;
			white_tiles = 0;
			colored_tiles = 0;
			discarded = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [8:0] data);
			case (idx)
				REG_WHITE_THR:    white_thr = data[7:0];
				REG_WHITE_SHARE:  white_share = data;
				REG_COLOR_THR:    color_thr = data[7:0];
				REG_COLOR_MARGIN: color_margin = data[7:0];
				REG_COLOR_SHARE:  color_share = data;
				default: ;
			endcase
		endfunction

		function bit leads(int unsigned top, int unsigned a, int unsigned b);
			return top > color_thr && top > a + color_margin && top > b + color_margin;
		endfunction

		function logic [17:0] bump(logic [17:0] v);
			return (v >= CNT_CAP) ? v : v + 18'd1;
		endfunction

		function void take_pixel(pixel_t p);
			int unsigned gray;
			longint unsigned total;
			verdict_t v;
			pixels++;
			gray = (p.c0 * WT_CH0 + p.c1 * WT_CH1 + p.c2 * WT_CH2 + WT_RND) >> 14;
			if (gray > white_thr)
				white_cnt = bump(white_cnt);
			if (leads(p.c1, p.c0, p.c2) || leads(p.c2, p.c0, p.c1))
				color_cnt = bump(color_cnt);
			pix_cnt = bump(pix_cnt);
			if (!p.last)
				return;
			total = pix_cnt;
			v.is_white = (64'(white_cnt) * 256) > (64'(white_share) * total);
			v.is_colored = (64'(color_cnt) * 256) > (64'(color_share) * total);
			v.discard = v.is_white | v.is_colored;
			v.white_total = white_cnt;
			v.color_total = color_cnt;
			pending_verdicts.push_back(v);
			white_cnt = '0;
			color_cnt = '0;
			pix_cnt = '0;
		endfunction

		function void check_verdict(verdict_t got);
			verdict_t want;
			tiles++;
			white_tiles += got.is_white;
			colored_tiles += got.is_colored;
			discarded += got.discard;
			if (pending_verdicts.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: verdict with none pending: w=%0b c=%0b d=%0b wt=%0d ct=%0d",
						$realtime, got.is_white, got.is_colored, got.discard,
						got.white_total, got.color_total);
				return;
			end
			want = pending_verdicts.pop_front();
			if (got.is_white !== want.is_white || got.is_colored !== want.is_colored ||
				got.discard !== want.discard || got.white_total !== want.white_total ||
				got.color_total !== want.color_total) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: verdict mismatch exp w=%0b c=%0b d=%0b wt=%0d ct=%0d, %s",
						$realtime, want.is_white, want.is_colored, want.discard,
						want.white_total, want.color_total,
						$sformatf("got w=%0b c=%0b d=%0b wt=%0d ct=%0d", got.is_white,
							got.is_colored, got.discard, got.white_total, got.color_total));
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_idx;
	logic [8:0] cfg_data;
	logic       sink_hold;
	bit         src_idle_on;
	bit         sink_idle_on;
	bit         idle_allowed;
	int         settings_used;
	event       hold_kick;
	tile_judge  judge;

	tbf_pix_if pix ();
	tbf_res_if res ();

	tile_background_filter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pix      (pix),
		.res      (res)
	);

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	pixel_t directed_px [17] = '{
		{8'd255, 8'd255, 8'd255, 1'b1},
		{8'd0,   8'd0,   8'd0,   1'b1},
		{8'd0,   8'd200, 8'd0,   1'b0},
		{8'd0,   8'd0,   8'd200, 1'b0},
		{8'd255, 8'd0,   8'd0,   1'b1},
		{8'd100, 8'd111, 8'd100, 1'b0},
		{8'd101, 8'd111, 8'd0,   1'b0},
		{8'd0,   8'd100, 8'd0,   1'b0},
		{8'd0,   8'd101, 8'd0,   1'b1},
		{8'd230, 8'd230, 8'd230, 1'b0},
		{8'd231, 8'd231, 8'd231, 1'b1},
		{8'd231, 8'd231, 8'd231, 1'b0},
		{8'd255, 8'd255, 8'd255, 1'b0},
		{8'd0,   8'd0,   8'd0,   1'b1},
		{8'd0,   8'd255, 8'd255, 1'b1},
		{8'd40,  8'd255, 8'd140, 1'b0},
		{8'd255, 8'd255, 8'd0,   1'b1}
	};

	function automatic pixel_t random_pixel();
		pixel_t p;
		logic [7:0] v;
		case ($urandom_range(0, 4))
			0: begin
				p.c0 = 8'($urandom);
				p.c1 = 8'($urandom);
				p.c2 = 8'($urandom);
			end
			1: begin
				p.c0 = 8'($urandom_range(190, 255));
				p.c1 = 8'($urandom_range(190, 255));
				p.c2 = 8'($urandom_range(190, 255));
			end
			2: begin
				p.c0 = 8'($urandom_range(0, 140));
				p.c1 = 8'($urandom_range(60, 255));
				p.c2 = 8'($urandom_range(0, 140));
			end
			3: begin
				p.c0 = 8'($urandom_range(0, 140));
				p.c1 = 8'($urandom_range(0, 140));
				p.c2 = 8'($urandom_range(60, 255));
			end
			default: begin
				v = 8'($urandom);
				p.c0 = v;
				p.c1 = v;
				p.c2 = v;
			end
		endcase
		p.last = 1'b0;
		return p;
	endfunction

	// One pixel transfer; valid stays high into the next call unless a gap is taken.
	task automatic drive_pixel(pixel_t p);
		if (src_idle_on && $urandom_range(0, 2) == 0) begin
			pix.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.chan_zero <= p.c0;
		pix.chan_one <= p.c1;
		pix.chan_two <= p.c2;
		pix.last_pixel <= p.last;
		do @(posedge clk); while (pix.ready !== 1'b1);
		judge.take_pixel(p);
	endtask

	task automatic send_tile(int len);
		pixel_t p;
		src_idle_on = idle_allowed && $urandom_range(0, 3) != 0;
		sink_idle_on = idle_allowed && $urandom_range(0, 3) != 0;
		for (int i = 0; i < len; i++) begin
			p = random_pixel();
			p.last = (i == len - 1);
			drive_pixel(p);
		end
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [8:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		judge.write_reg(idx, data);
	endtask

	// Writes all five registers plus one out-of-range index, which must be ignored.
	task automatic load_setting(setting_t s);
		cfg_write(REG_WHITE_THR, s.white_thr);
		cfg_write(REG_WHITE_SHARE, s.white_share);
		cfg_write(REG_COLOR_THR, s.color_thr);
		cfg_write(REG_COLOR_MARGIN, s.color_margin);
		cfg_write(REG_COLOR_SHARE, s.color_share);
		cfg_write(3'($urandom_range(REG_COUNT, 7)), 9'($urandom));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic settle();
		pix.valid <= 1'b0;
		while (judge.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
	initial begin
		sink_hold = 1'b0;
		forever begin
			@(hold_kick);
			sink_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			sink_hold <= 1'b0;
		end
	end

	// Verdict receiver: checks each transfer, then picks next cycle's ready.
	initial begin
		int stall_left;
		stall_left = 0;
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid === 1'b1 && res.ready)
				judge.check_verdict({res.is_white, res.is_colored, res.discard,
					res.white_total, res.color_total});
			if (sink_hold)
				res.ready <= 1'b0;
			else if (stall_left > 0) begin
				res.ready <= 1'b0;
				stall_left--;
			end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 2);
				res.ready <= 1'b0;
			end else
				res.ready <= 1'b1;
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("Timeout with %0d verdicts outstanding", judge.pending_verdicts.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		setting_t s;
		pixel_t p;
		int n;
		int len;
		judge = new();
		settings_used = 0;
		idle_allowed = 1'b1;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.chan_zero = '0;
		pix.chan_one = '0;
		pix.chan_two = '0;
		pix.last_pixel = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edge cases under the reset settings
		foreach (directed_px[i])
			drive_pixel(directed_px[i]);
		settle();

		// Fill the pipeline against a stalled receiver
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		-> hold_kick;
		for (int i = 0; i < 30; i++) begin
			p = random_pixel();
			p.last = 1'b1;
			drive_pixel(p);
		end
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: s = {9'd230, 9'd128, 9'd100, 9'd10, 9'd128};
				1: s = {9'd0, 9'd0, 9'd0, 9'd0, 9'd0};
				2: s = {9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF};
				3: s = {9'd255, 9'd256, 9'd255, 9'd255, 9'd256};
				default: begin
					s.white_thr = 9'($urandom_range(0, 511));
					s.white_share = ($urandom_range(0, 7) == 0) ?
						9'($urandom_range(257, 511)) : 9'($urandom_range(0, 256));
					s.color_thr = 9'($urandom_range(0, 511));
					s.color_margin = 9'($urandom_range(0, 60));
					s.color_share = ($urandom_range(0, 7) == 0) ?
						9'($urandom_range(257, 511)) : 9'($urandom_range(0, 256));
				end
			endcase
			load_setting(s);
			n = 0;
			while (n < PHASE_ITEMS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				send_tile(len);
				n += len;
			end
			settle();
		end

		// Closing part, no idling: one long tile, mostly green, under extreme ratios, then short random tiles
		idle_allowed = 1'b0;
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		load_setting({9'd0, 9'd255, 9'd0, 9'd0, 9'd256});
		for (int i = 0; i < LONG_TILE_LEN; i++) begin
			p = (i < 10) ? {8'd0, 8'd0, 8'd0, 1'b0} : {8'd0, 8'd255, 8'd0, 1'b0};
			p.last = (i == LONG_TILE_LEN - 1);
			drive_pixel(p);
		end
		settle();
		load_setting({9'd200, 9'd64, 9'd90, 9'd5, 9'd64});
		for (int i = 0; i < 8; i++)
			send_tile($urandom_range(1, 8));
		settle();

		judge.errors += judge.pending_verdicts.size();
		$display("Covered %0d pixels in %0d tiles under %0d register settings", judge.pixels,
			judge.tiles, settings_used);
		$display("Verdicts seen: %0d white, %0d colored, %0d discarded; %0d errors",
			judge.white_tiles, judge.colored_tiles, judge.discarded, judge.errors);
		if (judge.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
